// ===== src/wgd_pkg.sv =====
// ----------------------------------------------------------------------------
// wgd_pkg
// Types and constants shared by the wrist-glance detector files.
// ----------------------------------------------------------------------------
`default_nettype none

package wgd_pkg;

  localparam int unsigned ACCEL_W = 13;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned IDX_W   = 2;

  typedef logic signed [ACCEL_W-1:0] accel_t;
  typedef logic [TIME_W-1:0]         stamp_t;
  typedef logic [REG_W-1:0]          reg_val_t;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_TICK   = 1'b1;

  typedef enum logic [1:0] {
    MODE_INACTIVE  = 2'd0,
    MODE_ACTIVE    = 2'd1,
    MODE_TIMED_OUT = 2'd2
  } glance_mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_DOWNWARD = 2'd1,
    REG_AWAY     = 2'd2,
    REG_ROLL     = 2'd3
  } cfg_reg_t;

  // active box
  localparam accel_t ACT_X_LO = -13'sd500;
  localparam accel_t ACT_X_HI = 13'sd500;
  localparam accel_t ACT_Y_LO = -13'sd900;
  localparam accel_t ACT_Y_HI = 13'sd200;
  localparam accel_t ACT_Z_LO = -13'sd1100;
  localparam accel_t ACT_Z_HI = 13'sd0;

  // downward box
  localparam accel_t DWN_X_LO = 13'sd800;
  localparam accel_t DWN_X_HI = 13'sd1000;
  localparam accel_t DWN_Y_LO = -13'sd500;
  localparam accel_t DWN_Y_HI = 13'sd500;
  localparam accel_t DWN_Z_LO = -13'sd800;
  localparam accel_t DWN_Z_HI = 13'sd800;

  // away box
  localparam accel_t AWY_X_LO = -13'sd600;
  localparam accel_t AWY_X_HI = 13'sd600;
  localparam accel_t AWY_Y_LO = 13'sd850;
  localparam accel_t AWY_Y_HI = 13'sd1200;
  localparam accel_t AWY_Z_LO = -13'sd500;
  localparam accel_t AWY_Z_HI = 13'sd500;

  localparam reg_val_t TIMEOUT_RST  = 16'd0;
  localparam reg_val_t DOWNWARD_RST = 16'd1000;
  localparam reg_val_t AWAY_RST     = 16'd1000;
  localparam reg_val_t ROLL_RST     = 16'd500;

endpackage

`default_nettype wire

// ===== src/wgd_if.sv =====
// ----------------------------------------------------------------------------
// wgd_if
// Valid/ready channels of the wrist-glance detector: items in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wgd_item_if;
  import wgd_pkg::*;

  logic   valid;
  logic   ready;
  logic   action;
  accel_t accel_x;
  accel_t accel_y;
  accel_t accel_z;
  logic   last_in_batch;

  modport source (output valid, action, accel_x, accel_y, accel_z, last_in_batch,
                  input ready);
  modport sink   (input valid, action, accel_x, accel_y, accel_z, last_in_batch,
                  output ready);
endinterface

interface wgd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] glance_state;
  logic       state_changed;

  modport source (output valid, glance_state, state_changed, input ready);
  modport sink   (input valid, glance_state, state_changed, output ready);
endinterface

`default_nettype wire

// ===== src/wrist_glance_detector.sv =====
// ----------------------------------------------------------------------------
// wrist_glance_detector
// Glance detection from batched accelerometer samples and millisecond ticks.
// ----------------------------------------------------------------------------
// Takes one item (sample or tick) per clock while results are not stalled and
// gives one result per item. An accepted item is held in the input register,
// is evaluated against the box limits and the 48-bit time state in a single
// pass, and its result lands in the output register, from which it transfers.
// Throughput is one item per cycle while the output is not stalled, with the
// 48-bit clock add and compare setting the critical path of that pass. While a
// result waits, the input register still takes one item; further items wait
// until the output register frees. Registers are to be written through the plain
// write port only while the block is idle; the block does not enforce this.
`default_nettype none

module wrist_glance_detector (
  input  wire logic                  clk,
  input  wire logic                  rst,
  wgd_item_if.sink                   item,
  wgd_result_if.source               result,
  input  wire logic                  wr_en,
  input  wire logic [wgd_pkg::IDX_W-1:0] wr_index,
  input  wire wgd_pkg::reg_val_t     wr_data
);
  import wgd_pkg::*;

  // configuration
  reg_val_t timeout_len, downward_window_ms, away_window_ms, roll_win_len;

  // input register
  logic   in_valid;
  logic   in_action;
  accel_t in_x, in_y, in_z;
  logic   in_last;

  // output register
  logic         out_valid;
  glance_mode_t out_state;
  logic         out_changed;

  // detector state
  stamp_t       clock_ms, window_end_ms, last_active_ms;
  logic         unglanced_flag;
  glance_mode_t glance_mode;
  reg_val_t     timeout_left;
  logic         timeout_armed, batch_skip, batch_all_active, batch_any_active;

  stamp_t       clock_ms_next, window_end_ms_next, last_active_ms_next;
  logic         unglanced_flag_next;
  glance_mode_t glance_mode_next;
  reg_val_t     timeout_left_next;
  logic         timeout_armed_next, batch_skip_next, batch_all_active_next;
  logic         batch_any_active_next;

  logic         advance;
  logic         is_active, is_downward, is_away;
  logic         before_window, within_roll;
  stamp_t       tick_clock, downward_end, away_end;
  logic [TIME_W:0] roll_end;
  reg_val_t     left_dec;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign item.ready   = !in_valid || advance;

  assign result.valid         = out_valid;
  assign result.glance_state  = out_state;
  assign result.state_changed = out_changed;

  // box tests
  assign is_active = (in_x >= ACT_X_LO) && (in_x <= ACT_X_HI) &&
                     (in_y >= ACT_Y_LO) && (in_y <= ACT_Y_HI) &&
                     (in_z >= ACT_Z_LO) && (in_z <= ACT_Z_HI);
  assign is_downward = (in_x >= DWN_X_LO) && (in_x <= DWN_X_HI) &&
                       (in_y >= DWN_Y_LO) && (in_y <= DWN_Y_HI) &&
                       (in_z >= DWN_Z_LO) && (in_z <= DWN_Z_HI);
  assign is_away = (in_x >= AWY_X_LO) && (in_x <= AWY_X_HI) &&
                   (in_y >= AWY_Y_LO) && (in_y <= AWY_Y_HI) &&
                   (in_z >= AWY_Z_LO) && (in_z <= AWY_Z_HI);

  // time arithmetic
  assign tick_clock    = clock_ms + stamp_t'(1);
  assign downward_end  = clock_ms + stamp_t'(downward_window_ms);
  assign away_end      = clock_ms + stamp_t'(away_window_ms);
  assign roll_end      = {1'b0, last_active_ms} + (TIME_W+1)'(roll_win_len);
  assign before_window = clock_ms < window_end_ms;
  assign within_roll   = {1'b0, clock_ms} < roll_end;
  assign left_dec      = (timeout_left != '0) ? timeout_left - reg_val_t'(1)
                                              : timeout_left;

  always_comb begin
    clock_ms_next         = clock_ms;
    window_end_ms_next    = window_end_ms;
    last_active_ms_next   = last_active_ms;
    unglanced_flag_next   = unglanced_flag;
    glance_mode_next      = glance_mode;
    timeout_left_next     = timeout_left;
    timeout_armed_next    = timeout_armed;
    batch_skip_next       = batch_skip;
    batch_all_active_next = batch_all_active;
    batch_any_active_next = batch_any_active;

    if (in_action == ACTION_TICK) begin
      clock_ms_next = tick_clock;
      if (timeout_armed) begin
        timeout_left_next = left_dec;
        if (left_dec == '0) begin
          timeout_armed_next = 1'b0;
          glance_mode_next   = MODE_TIMED_OUT;
        end
      end
    end else begin
      if (!batch_skip) begin
        if (is_active) begin
          batch_any_active_next = 1'b1;
          last_active_ms_next   = clock_ms;
          if (in_last && batch_all_active && unglanced_flag && before_window) begin
            unglanced_flag_next = 1'b0;
            glance_mode_next    = MODE_ACTIVE;
            if (timeout_len != '0) begin
              timeout_armed_next = 1'b1;
              timeout_left_next  = timeout_len;
            end
          end
        end else if (is_downward || is_away) begin
          batch_all_active_next = 1'b0;
          unglanced_flag_next   = 1'b1;
          glance_mode_next      = MODE_INACTIVE;
          timeout_armed_next    = 1'b0;
          timeout_left_next     = '0;
          batch_skip_next       = 1'b1;
          if (is_downward) begin
            window_end_ms_next = downward_end;
          end else if (within_roll) begin
            window_end_ms_next = away_end;
          end
        end else begin
          batch_all_active_next = 1'b0;
          if (in_last && !batch_any_active) begin
            glance_mode_next   = MODE_INACTIVE;
            timeout_armed_next = 1'b0;
            timeout_left_next  = '0;
          end
        end
      end
      if (in_last) begin
        batch_skip_next       = 1'b0;
        batch_all_active_next = 1'b1;
        batch_any_active_next = 1'b0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_len        <= TIMEOUT_RST;
      downward_window_ms <= DOWNWARD_RST;
      away_window_ms     <= AWAY_RST;
      roll_win_len       <= ROLL_RST;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_TIMEOUT:  timeout_len        <= wr_data;
        REG_DOWNWARD: downward_window_ms <= wr_data;
        REG_AWAY:     away_window_ms     <= wr_data;
        REG_ROLL:     roll_win_len       <= wr_data;
        default:      timeout_len        <= timeout_len;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_action <= item.action;
      in_x      <= item.accel_x;
      in_y      <= item.accel_y;
      in_z      <= item.accel_z;
      in_last   <= item.last_in_batch;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state   <= glance_mode_next;
      out_changed <= (glance_mode_next != glance_mode);
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms         <= '0;
      window_end_ms    <= '0;
      last_active_ms   <= '0;
      unglanced_flag   <= 1'b1;
      glance_mode      <= MODE_INACTIVE;
      timeout_left     <= '0;
      timeout_armed    <= 1'b0;
      batch_skip       <= 1'b0;
      batch_all_active <= 1'b1;
      batch_any_active <= 1'b0;
    end else if (advance) begin
      clock_ms         <= clock_ms_next;
      window_end_ms    <= window_end_ms_next;
      last_active_ms   <= last_active_ms_next;
      unglanced_flag   <= unglanced_flag_next;
      glance_mode      <= glance_mode_next;
      timeout_left     <= timeout_left_next;
      timeout_armed    <= timeout_armed_next;
      batch_skip       <= batch_skip_next;
      batch_all_active <= batch_all_active_next;
      batch_any_active <= batch_any_active_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/wgd_checker.sv =====
// ----------------------------------------------------------------------------
// wgd_checker
// Port-level checks of the wrist-glance detector, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wgd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_ready,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire logic [1:0] glance_state,
  input wire logic       state_changed
);
  import wgd_pkg::*;

  logic [1:0] prev_state;
  logic [1:0] pending;
  logic       item_xfer, result_xfer;

  assign item_xfer   = item_valid && item_ready;
  assign result_xfer = result_valid && result_ready;

  // last delivered state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_state <= MODE_INACTIVE;
    end else if (result_xfer) begin
      prev_state <= glance_state;
    end
  end

  // items taken but results not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(item_xfer) - 2'(result_xfer);
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(glance_state) && $stable(state_changed))
    else $error("result changed while stalled");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state_changed == (glance_state != prev_state))
    else $error("state_changed disagrees with delivered state sequence");

  a_timeout_from_active: assert property (@(posedge clk) disable iff (rst)
    result_valid && state_changed && glance_state == MODE_TIMED_OUT |->
      prev_state == MODE_ACTIVE)
    else $error("timed out entered from a state other than active");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2 && (!result_valid || pending != 2'd0))
    else $error("result count out of step with accepted items");

endmodule

bind wrist_glance_detector wgd_checker u_wgd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .glance_state (result.glance_state),
  .state_changed(result.state_changed)
);

`default_nettype wire

// ===== dv/glance_checker.sv =====
// ----------------------------------------------------------------------------
// glance_checker
// Watches the item and result channels and the register write port of the
// wrist-glance detector. Keeps its own model of the glance state machine,
// predicts one result per accepted item and compares every result transfer
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module glance_checker (
  input  logic                      clk,
  input  logic                      rst,
  wgd_item_if                       item,
  wgd_result_if                     result,
  input  logic                      wr_en,
  input  logic [wgd_pkg::IDX_W-1:0] wr_index,
  input  wgd_pkg::reg_val_t         wr_data,
  output int                        fail_count,
  output int                        pending_count
);
  import wgd_pkg::*;

  typedef struct packed {
    glance_mode_t mode;
    logic         changed;
  } glance_result_t;

  glance_result_t expected_glances [$];
  glance_result_t got;
  glance_result_t want;
  int             mismatches;

  reg_val_t     timeout_len;
  reg_val_t     down_ms;
  reg_val_t     away_ms;
  reg_val_t     roll_ms;
  stamp_t       now_ms;
  stamp_t       window_end;
  stamp_t       last_active;
  logic         unglanced;
  glance_mode_t mode;
  reg_val_t     timeout_left;
  logic         armed;
  logic         skip_rest;
  logic         all_active;
  logic         any_active;

  function automatic logic in_box(input accel_t x, y, z,
                                  input accel_t xl, xh, yl, yh, zl, zh);
    return x >= xl && x <= xh && y >= yl && y <= yh && z >= zl && z <= zh;
  endfunction

  task automatic drop_glance();
    mode         = MODE_INACTIVE;
    armed        = 1'b0;
    timeout_left = '0;
  endtask

  task automatic predict_glance(input logic act, input accel_t x, y, z,
                                input logic last, output glance_result_t res);
    glance_mode_t prior;
    prior = mode;
    if (act == ACTION_TICK) begin
      now_ms = now_ms + stamp_t'(1);
      if (armed) begin
        if (timeout_left != '0) timeout_left = timeout_left - reg_val_t'(1);
        if (timeout_left == '0) begin
          armed = 1'b0;
          mode  = MODE_TIMED_OUT;
        end
      end
    end else begin
      if (!skip_rest) begin
        if (in_box(x, y, z, ACT_X_LO, ACT_X_HI, ACT_Y_LO, ACT_Y_HI, ACT_Z_LO, ACT_Z_HI)) begin
          any_active  = 1'b1;
          last_active = now_ms;
          if (last && all_active && unglanced && now_ms < window_end) begin
            unglanced = 1'b0;
            mode      = MODE_ACTIVE;
            if (timeout_len != '0) begin
              armed        = 1'b1;
              timeout_left = timeout_len;
            end
          end
        end else if (in_box(x, y, z, DWN_X_LO, DWN_X_HI, DWN_Y_LO, DWN_Y_HI,
                            DWN_Z_LO, DWN_Z_HI)) begin
          all_active = 1'b0;
          unglanced  = 1'b1;
          window_end = now_ms + stamp_t'(down_ms);
          drop_glance();
          skip_rest  = 1'b1;
        end else if (in_box(x, y, z, AWY_X_LO, AWY_X_HI, AWY_Y_LO, AWY_Y_HI,
                            AWY_Z_LO, AWY_Z_HI)) begin
          all_active = 1'b0;
          unglanced  = 1'b1;
          drop_glance();
          // roll window sum is taken one bit wider, no wrap
          if ({1'b0, now_ms} < {1'b0, last_active} + (TIME_W+1)'(roll_ms))
            window_end = now_ms + stamp_t'(away_ms);
          skip_rest  = 1'b1;
        end else begin
          all_active = 1'b0;
          if (last && !any_active) drop_glance();
        end
      end
      if (last) begin
        skip_rest  = 1'b0;
        all_active = 1'b1;
        any_active = 1'b0;
      end
    end
    res.mode    = mode;
    res.changed = (mode != prior);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_glances.delete();
      mismatches   = 0;
      timeout_len  = TIMEOUT_RST;
      down_ms      = DOWNWARD_RST;
      away_ms      = AWAY_RST;
      roll_ms      = ROLL_RST;
      now_ms       = '0;
      window_end   = '0;
      last_active  = '0;
      unglanced    = 1'b1;
      mode         = MODE_INACTIVE;
      timeout_left = '0;
      armed        = 1'b0;
      skip_rest    = 1'b0;
      all_active   = 1'b1;
      any_active   = 1'b0;
    end else begin
      if (wr_en) begin
        case (cfg_reg_t'(wr_index))
          REG_TIMEOUT:  timeout_len = wr_data;
          REG_DOWNWARD: down_ms     = wr_data;
          REG_AWAY:     away_ms     = wr_data;
          REG_ROLL:     roll_ms     = wr_data;
          default: ;
        endcase
      end
      // results trail items through the input and output registers, so compare before predicting
      if (result.valid && result.ready) begin
        if (expected_glances.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transfer: state %0d changed %0d",
                     result.glance_state, result.state_changed);
          mismatches++;
        end else begin
          want = expected_glances.pop_front();
          if (result.glance_state !== want.mode ||
              result.state_changed !== want.changed) begin
            if (mismatches < 10)
              $display({"result mismatch: expected state %0d changed %0d, ",
                        "got state %0d changed %0d"},
                       want.mode, want.changed, result.glance_state,
                       result.state_changed);
            mismatches++;
          end
        end
      end
      if (item.valid && item.ready) begin
        predict_glance(item.action, item.accel_x, item.accel_y, item.accel_z,
                       item.last_in_batch, got);
        expected_glances.push_back(got);
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_glances.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the wrist-glance detector: a short directed sequence of the
// box corners, skipped batches, mixed and dead batches and ticks inside a
// batch, then random batches and tick bursts under several register settings,
// with random gaps on the item side and random stalls on the result side.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------

module tb_top;
  import wgd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  localparam int SMP_ACTIVE = 0;
  localparam int SMP_DOWN   = 1;
  localparam int SMP_AWAY   = 2;
  localparam int SMP_NEAR   = 3;
  localparam int SMP_ANY    = 4;

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic [IDX_W-1:0] wr_index;
  reg_val_t         wr_data;

  int idle_pct;
  int stall_pct;
  int items_sent;
  int cycles = 0;
  int fail_count;
  int pending_count;

  wgd_item_if   item_ch ();
  wgd_result_if result_ch ();

  wrist_glance_detector i_dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  glance_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .item          (item_ch),
    .result        (result_ch),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("wrist_glance_detector: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic accel_t pick(input accel_t lo, input accel_t hi);
    int r;
    r = $urandom_range(9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return accel_t'(int'(lo) + int'($urandom_range(int'(hi) - int'(lo))));
  endfunction

  function automatic accel_t pick_any();
    return accel_t'($urandom);
  endfunction

  task automatic send_item(input logic act, input accel_t x, y, z, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.action        <= act;
    item_ch.accel_x       <= x;
    item_ch.accel_y       <= y;
    item_ch.accel_z       <= z;
    item_ch.last_in_batch <= last;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(ACTION_TICK, pick_any(), pick_any(), pick_any(), 1'($urandom));
  endtask

  task automatic send_sample(input int kind, input logic last);
    accel_t x, y, z;
    case (kind)
      SMP_ACTIVE, SMP_NEAR: begin
        x = pick(ACT_X_LO, ACT_X_HI);
        y = pick(ACT_Y_LO, ACT_Y_HI);
        z = pick(ACT_Z_LO, ACT_Z_HI);
        if (kind == SMP_NEAR) begin
          // one axis just outside the active box
          case ($urandom_range(5))
            0:       x = ACT_X_LO - 13'sd1;
            1:       x = ACT_X_HI + 13'sd1;
            2:       y = ACT_Y_LO - 13'sd1;
            3:       y = ACT_Y_HI + 13'sd1;
            4:       z = ACT_Z_LO - 13'sd1;
            default: z = ACT_Z_HI + 13'sd1;
          endcase
        end
      end
      SMP_DOWN: begin
        x = pick(DWN_X_LO, DWN_X_HI);
        y = pick(DWN_Y_LO, DWN_Y_HI);
        z = pick(DWN_Z_LO, DWN_Z_HI);
      end
      SMP_AWAY: begin
        x = pick(AWY_X_LO, AWY_X_HI);
        y = pick(AWY_Y_LO, AWY_Y_HI);
        z = pick(AWY_Z_LO, AWY_Z_HI);
      end
      default: begin
        x = pick_any();
        y = pick_any();
        z = pick_any();
      end
    endcase
    send_item(ACTION_SAMPLE, x, y, z, last);
  endtask

  task automatic send_batch();
    int   len;
    int   r;
    int   kind;
    logic clean;
    logic last;
    len   = $urandom_range(4, 1);
    clean = ($urandom_range(1) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(4) == 0) send_tick();
      last = (i == len - 1);
      if ($urandom_range(31) == 0) last = ~last;
      r = $urandom_range(99);
      if (clean || r < 55) kind = SMP_ACTIVE;
      else if (r < 67)     kind = SMP_DOWN;
      else if (r < 77)     kind = SMP_AWAY;
      else if (r < 87)     kind = SMP_NEAR;
      else                 kind = SMP_ANY;
      send_sample(kind, last);
    end
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input reg_val_t val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input reg_val_t t, d, a, r);
    put_reg(REG_TIMEOUT, t);
    put_reg(REG_DOWNWARD, d);
    put_reg(REG_AWAY, a);
    put_reg(REG_ROLL, r);
    wr_en <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int goal;
    int r;
    goal = items_sent + count;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 30) repeat ($urandom_range(6, 1)) send_tick();
      else if (r < 92) send_batch();
      else send_sample(SMP_ANY, 1'($urandom));
      if ($urandom_range(149) == 0) drain();
    end
  endtask

  initial begin
    idle_pct   = 24;
    stall_pct  = 24;
    items_sent = 0;
    rst                   <= 1'b1;
    wr_en                 <= 1'b0;
    wr_index              <= REG_TIMEOUT;
    wr_data               <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.action        <= ACTION_SAMPLE;
    item_ch.accel_x       <= '0;
    item_ch.accel_y       <= '0;
    item_ch.accel_z       <= '0;
    item_ch.last_in_batch <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // no window opened yet, active cannot fire
    send_item(ACTION_SAMPLE, 13'sd0, -13'sd100, -13'sd500, 1'b1);
    // downward corner, rest of batch skipped
    send_item(ACTION_SAMPLE, DWN_X_LO, DWN_Y_LO, DWN_Z_LO, 1'b0);
    send_item(ACTION_SAMPLE, ACT_X_LO, ACT_Y_LO, ACT_Z_LO, 1'b1);
    // active batch on the box corners
    send_item(ACTION_SAMPLE, ACT_X_LO, ACT_Y_LO, ACT_Z_LO, 1'b0);
    send_item(ACTION_SAMPLE, ACT_X_HI, ACT_Y_HI, ACT_Z_HI, 1'b1);
    send_item(ACTION_TICK, -13'sd4096, 13'sd4095, -13'sd4096, 1'b1);
    // dead batch
    send_item(ACTION_SAMPLE, -13'sd4096, -13'sd4096, -13'sd4096, 1'b1);
    // mixed batch
    send_item(ACTION_SAMPLE, ACT_X_HI, ACT_Y_LO, ACT_Z_HI, 1'b0);
    send_item(ACTION_SAMPLE, 13'sd4095, 13'sd4095, 13'sd4095, 1'b1);
    // away inside the roll window
    send_item(ACTION_SAMPLE, AWY_X_HI, AWY_Y_HI, AWY_Z_HI, 1'b1);
    send_item(ACTION_SAMPLE, ACT_X_LO, ACT_Y_HI, ACT_Z_LO, 1'b1);
    send_item(ACTION_SAMPLE, AWY_X_LO, AWY_Y_LO, AWY_Z_LO, 1'b1);
    // tick inside a batch
    send_item(ACTION_SAMPLE, 13'sd0, 13'sd0, -13'sd1, 1'b0);
    send_item(ACTION_TICK, 13'sd0, 13'sd0, 13'sd0, 1'b0);
    send_item(ACTION_SAMPLE, -13'sd1, -13'sd1, -13'sd1, 1'b1);
    send_item(ACTION_SAMPLE, DWN_X_HI, DWN_Y_HI, DWN_Z_HI, 1'b1);
    // just outside the active box
    send_item(ACTION_SAMPLE, ACT_X_HI + 13'sd1, ACT_Y_HI, ACT_Z_HI, 1'b1);
    send_item(ACTION_SAMPLE, ACT_X_LO, ACT_Y_LO, ACT_Z_HI + 13'sd1, 1'b1);

    drain();
    set_config(16'd5, 16'd30, 16'd20, 16'd10);
    run_random(360);

    // no idling on either side
    drain();
    idle_pct  = 0;
    stall_pct = 0;
    set_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(360);

    drain();
    idle_pct  = 24;
    stall_pct = 24;
    set_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    run_random(360);

    drain();
    set_config(16'd1, 16'd3, 16'd3, 16'd2);
    run_random(360);

    drain();
    set_config(16'd7, DOWNWARD_RST, AWAY_RST, ROLL_RST);
    run_random(360);

    drain();
    if (fail_count == 0) begin
      $display("wrist_glance_detector: match");
    end else begin
      $display("wrist_glance_detector: mismatch");
    end
    $finish;
  end

endmodule
